// ===== src/spimbe_pkg.sv =====
// ----------------------------------------------------------------------------
// spimbe_pkg
// Shared types and codes for the SPI master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package spimbe_pkg;

   typedef enum logic [2:0] {
      KIND_TICK     = 3'd0,
      KIND_START    = 3'd1,
      KIND_SELECT   = 3'd2,
      KIND_DESELECT = 3'd3,
      KIND_SET_BRK  = 3'd4,
      KIND_CLR_BRK  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DISABLED  = 2'd1,
      ST_BUSY      = 2'd2,
      ST_NO_BREAK  = 2'd3
   } status_type;

   // register indexes (word address)
   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_SPI_MODE = 2'd1;
   localparam logic [1:0] REG_SS_POL   = 2'd2;
   localparam logic [1:0] REG_HALF_PER = 2'd3;

   localparam int unsigned CSR_ADDR_BITS = 4;
   localparam int unsigned CSR_DATA_BITS = 32;

   // fields of one input item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_data;
      logic [3:0]  bit_count;
      logic        last_frame;
      logic        end_hold;
      logic        end_sck_level;
      logic        mosi_level;
      logic        sck_level;
      logic        miso;
   } req_type;

   // fields of one result item
   typedef struct packed {
      status_type  status;
      logic        busy_res;
      logic        frame_done;
      logic [7:0]  rx_data;
      logic        ss_pin;
      logic        mosi_pin;
      logic        sck_pin;
   } rsp_type;

   // static config plus enable transition events, csr -> core
   typedef struct packed {
      logic        enable;
      logic [1:0]  spi_mode;
      logic        ss_active_high;
      logic        enable_rise;
      logic        enable_fall;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/spimbe_csr.sv =====
// ----------------------------------------------------------------------------
// spimbe_csr
// APB register file: enable, spi_mode, ss polarity, half period.
// ----------------------------------------------------------------------------
`default_nettype none

module spimbe_csr
   import spimbe_pkg::*;
#(
   parameter int unsigned HALF_PERIOD_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                             csr_pready,
   output cfg_type                          cfg,
   output logic      [HALF_PERIOD_BITS-1:0] half_period
);

   localparam int unsigned HP_RESET = 16 % (1 << HALF_PERIOD_BITS);

   logic                        enable_ff, enable_in;
   logic [1:0]                  spi_mode_ff, spi_mode_in;
   logic                        ss_pol_ff, ss_pol_in;
   logic [HALF_PERIOD_BITS-1:0] half_per_ff, half_per_in;
   logic                        wr;
   logic [1:0]                  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_comb begin
      enable_in   = enable_ff;
      spi_mode_in = spi_mode_ff;
      ss_pol_in   = ss_pol_ff;
      half_per_in = half_per_ff;
      if (wr) begin
         unique case (idx)
            REG_ENABLE:   enable_in   = csr_pwdata[0];
            REG_SPI_MODE: spi_mode_in = csr_pwdata[1:0];
            REG_SS_POL:   ss_pol_in   = csr_pwdata[0];
            REG_HALF_PER: half_per_in = csr_pwdata[HALF_PERIOD_BITS-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         spi_mode_ff <= 2'd0;
         ss_pol_ff   <= 1'b0;
         half_per_ff <= HALF_PERIOD_BITS'(HP_RESET);
      end else begin
         enable_ff   <= enable_in;
         spi_mode_ff <= spi_mode_in;
         ss_pol_ff   <= ss_pol_in;
         half_per_ff <= half_per_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_ENABLE:   csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, enable_ff};
         REG_SPI_MODE: csr_prdata = {{(CSR_DATA_BITS-2){1'b0}}, spi_mode_ff};
         REG_SS_POL:   csr_prdata = {{(CSR_DATA_BITS-1){1'b0}}, ss_pol_ff};
         REG_HALF_PER: csr_prdata = {{(CSR_DATA_BITS-HALF_PERIOD_BITS){1'b0}}, half_per_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.enable         = enable_ff;
   assign cfg.spi_mode       = spi_mode_ff;
   assign cfg.ss_active_high = ss_pol_ff;
   assign cfg.enable_rise    = enable_in & ~enable_ff;
   assign cfg.enable_fall    = ~enable_in & enable_ff;
   assign half_period        = half_per_ff;

endmodule

`default_nettype wire

// ===== src/spimbe_core.sv =====
// ----------------------------------------------------------------------------
// spimbe_core
// Bit engine state and combinational item processing into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module spimbe_core
   import spimbe_pkg::*;
#(
   parameter int unsigned HALF_PERIOD_BITS = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfg_type                     cfg,
   input  wire logic [HALF_PERIOD_BITS-1:0] half_period,
   input  wire logic                        accept,
   input  wire req_type                     req,
   output rsp_type                          res
);

   logic [7:0]                  shift_ff, shift_in;
   logic [3:0]                  bits_ff, bits_in;
   logic                        second_ff, second_in;
   logic [HALF_PERIOD_BITS-1:0] tick_ff, tick_in;
   logic                        running_ff, running_in;
   logic                        break_ff, break_in;
   logic                        sck_ff, sck_in;
   logic                        mosi_ff, mosi_in;
   logic                        ss_ff, ss_in;
   logic                        hold_ff, hold_in;
   logic                        final_ff, final_in;

   logic                        cpol, cpha;
   logic [HALF_PERIOD_BITS-1:0] tick_inc, hp_eff;
   logic                        half_end;
   logic [3:0]                  bits_dec;
   logic [7:0]                  shift_smp;
   logic [3:0]                  nbits;
   logic [2:0]                  amt;
   logic [7:0]                  shift_start;
   logic [7:0]                  rx;
   logic                        done;
   status_type                  status;

   assign cpol      = cfg.spi_mode[1];
   assign cpha      = cfg.spi_mode[0];
   assign tick_inc  = tick_ff + HALF_PERIOD_BITS'(1);
   assign hp_eff    = (half_period == '0) ? HALF_PERIOD_BITS'(1) : half_period;
   assign half_end  = (tick_inc >= hp_eff) || (tick_inc == '0);
   assign bits_dec  = bits_ff - 4'd1;
   assign shift_smp = shift_ff | {7'd0, req.miso};

   // frame length: 8 in normal state, clamped bit_count in break
   always_comb begin
      if (!break_ff)                  nbits = 4'd8;
      else if (req.bit_count == 4'd0) nbits = 4'd1;
      else if (req.bit_count > 4'd8)  nbits = 4'd8;
      else                            nbits = req.bit_count;
   end
   assign amt         = 3'(4'd8 - nbits);
   assign shift_start = req.tx_data << amt;

   always_comb begin
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      second_in  = second_ff;
      tick_in    = tick_ff;
      running_in = running_ff;
      break_in   = break_ff;
      sck_in     = sck_ff;
      mosi_in    = mosi_ff;
      ss_in      = ss_ff;
      hold_in    = hold_ff;
      final_in   = final_ff;
      rx         = 8'd0;
      done       = 1'b0;
      status     = ST_OK;

      if (cfg.enable_rise) begin
         ss_in    = ~cfg.ss_active_high;
         mosi_in  = 1'b1;
         sck_in   = cpol;
         break_in = 1'b0;
      end else if (cfg.enable_fall) begin
         running_in = 1'b0;
         break_in   = 1'b0;
         bits_in    = 4'd0;
         second_in  = 1'b0;
         tick_in    = '0;
      end else if (accept) begin
         if (req.kind == KIND_TICK) begin
            if (running_ff) begin
               tick_in = tick_inc;
               if (half_end) begin
                  tick_in = '0;
                  if (!second_ff) begin
                     if (!cpha) begin
                        shift_in = shift_smp;
                     end else begin
                        mosi_in  = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                     end
                     // held last edge goes to the requested level
                     sck_in    = ((hold_ff && bits_ff == 4'd1) ? final_ff : 1'b0) ^ cpol;
                     second_in = 1'b1;
                  end else begin
                     second_in = 1'b0;
                     bits_in   = bits_dec;
                     shift_in  = cpha ? shift_smp : shift_ff;
                     if (bits_dec == 4'd0) begin
                        running_in = 1'b0;
                        done       = 1'b1;
                        rx         = cpha ? shift_smp : shift_ff;
                     end else begin
                        if (!cpha) begin
                           mosi_in  = shift_in[7];
                           shift_in = {shift_in[6:0], 1'b0};
                        end
                        sck_in = ~cpol;
                     end
                  end
               end
            end
         end else if (req.kind == KIND_START || req.kind == KIND_SELECT ||
                      req.kind == KIND_DESELECT || req.kind == KIND_SET_BRK ||
                      req.kind == KIND_CLR_BRK) begin
            if (!cfg.enable) begin
               status = ST_DISABLED;
            end else if (running_ff) begin
               status = ST_BUSY;
            end else if (req.kind == KIND_CLR_BRK && !break_ff) begin
               status = ST_NO_BREAK;
            end else begin
               unique case (req.kind)
                  KIND_START: begin
                     bits_in    = nbits;
                     hold_in    = break_ff & req.last_frame & req.end_hold;
                     final_in   = req.end_sck_level;
                     running_in = 1'b1;
                     second_in  = 1'b0;
                     tick_in    = '0;
                     if (!cpha) begin
                        mosi_in  = shift_start[7];
                        shift_in = {shift_start[6:0], 1'b0};
                     end else begin
                        shift_in = shift_start;
                     end
                     sck_in = ~cpol;
                  end
                  KIND_SELECT:   ss_in = cfg.ss_active_high;
                  KIND_DESELECT: ss_in = ~cfg.ss_active_high;
                  KIND_SET_BRK: begin
                     mosi_in  = req.mosi_level;
                     sck_in   = req.sck_level;
                     break_in = 1'b1;
                     rx       = {7'd0, req.miso};
                  end
                  KIND_CLR_BRK: begin
                     mosi_in  = 1'b1;
                     sck_in   = cpol;
                     break_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= 8'd0;
         bits_ff    <= 4'd0;
         second_ff  <= 1'b0;
         tick_ff    <= '0;
         running_ff <= 1'b0;
         break_ff   <= 1'b0;
         sck_ff     <= 1'b0;
         mosi_ff    <= 1'b1;
         ss_ff      <= 1'b1;
         hold_ff    <= 1'b0;
         final_ff   <= 1'b0;
      end else begin
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         second_ff  <= second_in;
         tick_ff    <= tick_in;
         running_ff <= running_in;
         break_ff   <= break_in;
         sck_ff     <= sck_in;
         mosi_ff    <= mosi_in;
         ss_ff      <= ss_in;
         hold_ff    <= hold_in;
         final_ff   <= final_in;
      end
   end

   assign res.status     = status;
   assign res.busy_res   = running_in;
   assign res.frame_done = done;
   assign res.rx_data    = rx;
   assign res.ss_pin     = ss_in;
   assign res.mosi_pin   = mosi_in;
   assign res.sck_pin    = sck_in;

   a_run_enabled: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> cfg.enable)
      else $error("frame running while disabled");

   a_run_bits: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (bits_ff != 4'd0))
      else $error("frame running with no bits left");

   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      res.frame_done |-> (res.status == ST_OK && !res.busy_res))
      else $error("frame done with bad status or still busy");

endmodule

`default_nettype wire

// ===== src/spimbe_out_buf.sv =====
// ----------------------------------------------------------------------------
// spimbe_out_buf
// Result register with skid stage; decouples input accept from rsp stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module spimbe_out_buf
   import spimbe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    main_v_ff, main_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take, push;

   assign in_ready = ~skid_v_ff;
   assign take     = main_v_ff & out_ready;
   assign push     = in_valid & ~skid_v_ff;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (take) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!main_v_ff || take) begin
            main_in   = in_data;
            main_v_in = 1'b1;
         end else begin
            skid_in   = in_data;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> main_v_ff)
      else $error("skid holds an item while result register is empty");

endmodule

`default_nettype wire

// ===== src/spi_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// spi_master_bit_engine
// SPI master bit engine with CPOL/CPHA modes and a direct-pin break state.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands: tick, start frame, select, deselect, set break
//   levels, clear break (kind on tuser, last_frame on tlast). Every item
//   gives exactly one rsp_* item with pin levels, rx byte, frame_done,
//   busy and a status code. Bit timing is driven by tick items: each SCK
//   half period lasts half_period ticks (a half_period of 0 acts as 1).
//   Results go through the result register. Throughput: one item per cycle
//   while the receiver keeps up; all state updates in a single combinational
//   pass between the state registers and the result register.
//   If the receiver stalls, one more item is taken into a skid stage, then
//   req_tready drops until the result register drains.
//   Reset: block disabled, SCK 0, MOSI 1, SS 1, half_period 16, mode 0.
//   Registers (APB, byte address 4*i): enable, spi_mode, ss_active_high,
//   half_period. Write them only while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_master_bit_engine
   import spimbe_pkg::*;
#(
   parameter int unsigned HALF_PERIOD_BITS = 12
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // tdata: tx_data[7:0], bit_count[11:8], end_hold[12], end_sck_level[13],
   //        mosi_level[14], sck_level[15], miso[16], zero pad [23:17]
   input  wire logic [23:0]              req_tdata,
   // tuser: kind[2:0]
   input  wire logic [2:0]               req_tuser,
   input  wire logic                     req_tlast,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // tdata: sck_pin[0], mosi_pin[1], ss_pin[2], rx_data[10:3],
   //        frame_done[11], busy_res[12], status[14:13], zero pad [15]
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type                     cfg;
   logic [HALF_PERIOD_BITS-1:0] half_period;
   req_type                     req;
   rsp_type                     res;
   rsp_type                     rsp;
   logic                        accept;

   assign req.kind          = kind_type'(req_tuser);
   assign req.tx_data       = req_tdata[7:0];
   assign req.bit_count     = req_tdata[11:8];
   assign req.last_frame    = req_tlast;
   assign req.end_hold      = req_tdata[12];
   assign req.end_sck_level = req_tdata[13];
   assign req.mosi_level    = req_tdata[14];
   assign req.sck_level     = req_tdata[15];
   assign req.miso          = req_tdata[16];

   assign accept = req_tvalid & req_tready;

   spimbe_csr #(
      .HALF_PERIOD_BITS(HALF_PERIOD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .half_period (half_period)
   );

   spimbe_core #(
      .HALF_PERIOD_BITS(HALF_PERIOD_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .half_period (half_period),
      .accept      (accept),
      .req         (req),
      .res         (res)
   );

   spimbe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {1'b0, rsp};

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams command items into the SPI master bit engine and checks every pin
// report against a cycle-free model of the shifter, timer and break state.
// The CSR port is reprogrammed between phases while the stream is drained.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spimbe_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 80;
   localparam logic [2:0] KIND_UNUSED = 3'd6;
   localparam int MISO_LOW = 0;
   localparam int MISO_HIGH = 1;
   localparam int MISO_RANDOM = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   spi_master_bit_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // register shadow
   logic        cfg_enable = 1'b0;
   logic [1:0]  cfg_mode = 2'd0;
   logic        cfg_ss_high = 1'b0;
   logic [11:0] cfg_half = 12'd16;

   // engine shadow
   logic [7:0]  eng_shift = '0;
   logic [3:0]  eng_bits_left = '0;
   logic        eng_second_half = 1'b0;
   logic [11:0] eng_ticks = '0;
   logic        eng_running = 1'b0;
   logic        eng_break = 1'b0;
   logic        eng_sck = 1'b0;
   logic        eng_mosi = 1'b1;
   logic        eng_ss = 1'b1;
   logic        eng_hold_end = 1'b0;
   logic        eng_end_level = 1'b0;

   req_type commands_to_send[$];
   rsp_type pin_reports_due[$];
   req_type cmd_on_bus;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  queued_in_phase = 0;
   int  mismatch_count = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   bit  stream_drained = 1'b0;

   // ---------------------------------------------------------------- model
   function automatic void drive_sck(input logic level);
      eng_sck = level ^ cfg_mode[1];
   endfunction

   function automatic void shift_out_bit();
      eng_mosi = eng_shift[7];
      eng_shift = eng_shift << 1;
   endfunction

   // first half of a bit: CPHA 0 puts data out together with the leading edge
   function automatic void lead_bit();
      if (!cfg_mode[0]) shift_out_bit();
      drive_sck(1'b1);
   endfunction

   function automatic rsp_type engine_step(input req_type r);
      rsp_type     o;
      logic [11:0] hp;
      logic [3:0]  n;
      logic        at_end;
      o = '0;
      o.status = ST_OK;
      if (r.kind == KIND_TICK) begin
         if (eng_running) begin
            hp = (cfg_half == 0) ? 12'd1 : cfg_half;
            eng_ticks = eng_ticks + 12'd1;
            if (eng_ticks >= hp || eng_ticks == 0) begin
               eng_ticks = '0;
               if (!eng_second_half) begin
                  at_end = eng_hold_end && eng_bits_left == 4'd1;
                  if (!cfg_mode[0]) eng_shift[0] = eng_shift[0] | r.miso;
                  else shift_out_bit();
                  drive_sck(at_end ? eng_end_level : 1'b0);
                  eng_second_half = 1'b1;
               end else begin
                  if (cfg_mode[0]) eng_shift[0] = eng_shift[0] | r.miso;
                  eng_second_half = 1'b0;
                  eng_bits_left = eng_bits_left - 4'd1;
                  if (eng_bits_left == 0) begin
                     eng_running = 1'b0;
                     o.frame_done = 1'b1;
                     o.rx_data = eng_shift;
                  end else begin
                     lead_bit();
                  end
               end
            end
         end
      end else if (r.kind <= KIND_CLR_BRK) begin
         if (!cfg_enable) o.status = ST_DISABLED;
         else if (eng_running) o.status = ST_BUSY;
         else if (r.kind == KIND_CLR_BRK && !eng_break) o.status = ST_NO_BREAK;
         else begin
            case (r.kind)
               KIND_START: begin
                  n = 4'd8;
                  if (eng_break)
                     n = (r.bit_count == 0) ? 4'd1 : (r.bit_count > 8 ? 4'd8 : r.bit_count);
                  // short break frames go out from the top of the byte
                  eng_shift = r.tx_data << (8 - n);
                  eng_bits_left = n;
                  eng_hold_end = eng_break && r.last_frame && r.end_hold;
                  eng_end_level = r.end_sck_level;
                  eng_running = 1'b1;
                  eng_second_half = 1'b0;
                  eng_ticks = '0;
                  lead_bit();
               end
               KIND_SELECT:   eng_ss = cfg_ss_high;
               KIND_DESELECT: eng_ss = !cfg_ss_high;
               KIND_SET_BRK: begin
                  eng_mosi = r.mosi_level;
                  eng_sck = r.sck_level;
                  eng_break = 1'b1;
                  o.rx_data = {7'd0, r.miso};
               end
               default: begin
                  eng_mosi = 1'b1;
                  eng_sck = cfg_mode[1];
                  eng_break = 1'b0;
               end
            endcase
         end
      end
      o.sck_pin = eng_sck;
      o.mosi_pin = eng_mosi;
      o.ss_pin = eng_ss;
      o.busy_res = eng_running;
      return o;
   endfunction

   // ------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t: result %0d: %s is %0h, predicted %0h",
                  $realtime, results_seen, what, got, want);
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (pin_reports_due.size() == 0) begin
         report_mismatch("unrequested result", int'(got), 0);
      end else begin
         want = pin_reports_due.pop_front();
         if (got.sck_pin !== want.sck_pin)
            report_mismatch("sck_pin", got.sck_pin, want.sck_pin);
         if (got.mosi_pin !== want.mosi_pin)
            report_mismatch("mosi_pin", got.mosi_pin, want.mosi_pin);
         if (got.ss_pin !== want.ss_pin)
            report_mismatch("ss_pin", got.ss_pin, want.ss_pin);
         if (got.rx_data !== want.rx_data)
            report_mismatch("rx_data", got.rx_data, want.rx_data);
         if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
         if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
         if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
      end
   endtask

   // ------------------------------------------------------ driver / monitor
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd_on_bus = commands_to_send.pop_front();
            req_tdata <= {7'd0, cmd_on_bus.miso, cmd_on_bus.sck_level, cmd_on_bus.mosi_level,
                          cmd_on_bus.end_sck_level, cmd_on_bus.end_hold,
                          cmd_on_bus.bit_count, cmd_on_bus.tx_data};
            req_tuser <= cmd_on_bus.kind;
            req_tlast <= cmd_on_bus.last_frame;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) check_response(rsp_type'(rsp_tdata[14:0]));
      if (req_fire) pin_reports_due.push_back(engine_step(cmd_on_bus));
      stream_drained = commands_to_send.size() == 0 && !req_tvalid
                       && pin_reports_due.size() == 0;
      if (reset || req_fire || rsp_fire) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic req_type command_of(input logic [2:0] k);
      req_type r;
      r.kind = kind_type'(k);
      r.tx_data = 8'($urandom);
      r.bit_count = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      r.last_frame = 1'($urandom);
      r.end_hold = 1'($urandom);
      r.end_sck_level = 1'($urandom);
      r.mosi_level = 1'($urandom);
      r.sck_level = 1'($urandom);
      r.miso = 1'($urandom);
      return r;
   endfunction

   function automatic int frame_ticks();
      return 16 * ((cfg_half == 0) ? 1 : int'(cfg_half)) + 2;
   endfunction

   task automatic push_command(input req_type r);
      commands_to_send.push_back(r);
      queued_in_phase++;
   endtask

   task automatic push_ticks(input int n, input int miso_sel);
      req_type r;
      for (int t = 0; t < n; t++) begin
         r = command_of(KIND_TICK);
         if (miso_sel != MISO_RANDOM) r.miso = miso_sel[0];
         push_command(r);
      end
   endtask

   // returns at a falling edge once every item has been answered
   task automatic wait_drained();
      do @(negedge clock); while (!stream_drained);
   endtask

   task automatic finish_frames();
      wait_drained();
      while (eng_running) begin
         push_ticks(frame_ticks(), MISO_RANDOM);
         wait_drained();
      end
   endtask

   // called at a falling edge with the stream drained
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_ENABLE: begin
            if (value[0] && !cfg_enable) begin
               cfg_enable = 1'b1;
               eng_ss = !cfg_ss_high;
               eng_mosi = 1'b1;
               eng_sck = cfg_mode[1];
               eng_break = 1'b0;
            end else if (!value[0] && cfg_enable) begin
               // disable aborts a running frame
               cfg_enable = 1'b0;
               eng_running = 1'b0;
               eng_break = 1'b0;
               eng_bits_left = '0;
               eng_second_half = 1'b0;
               eng_ticks = '0;
            end
         end
         REG_SPI_MODE: cfg_mode = value[1:0];
         REG_SS_POL:   cfg_ss_high = value[0];
         default:      cfg_half = value[11:0];
      endcase
      // bus returns to idle between accesses
      @(negedge clock);
   endtask

   // random commands, or optional select and break, one to three frames, optional deselect and clear
   task automatic add_transaction();
      req_type r;
      int      n;
      int      frames;
      logic    brk;
      if ($urandom_range(9) < 2) begin
         repeat ($urandom_range(1, 4)) push_command(command_of(3'($urandom_range(7))));
         return;
      end
      brk = 1'($urandom);
      frames = $urandom_range(1, 3);
      if ($urandom_range(3) != 0) push_command(command_of(KIND_SELECT));
      if (brk) push_command(command_of(KIND_SET_BRK));
      for (int f = 1; f <= frames; f++) begin
         r = command_of(KIND_START);
         r.last_frame = (f == frames);
         push_command(r);
         n = frame_ticks();
         if ($urandom_range(7) == 0) n = $urandom_range(0, n);
         for (int t = 0; t < n; t++) begin
            if ($urandom_range(15) == 0) push_command(command_of(3'($urandom_range(7))));
            else push_command(command_of(KIND_TICK));
         end
      end
      if ($urandom_range(3) != 0) push_command(command_of(KIND_DESELECT));
      if (brk && $urandom_range(3) != 0) push_command(command_of(KIND_CLR_BRK));
   endtask

   initial begin
      req_type r;
      int      mode;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every command kind is refused while disabled; ticks and unused kinds are ignored
      for (int k = 0; k < 8; k++) push_command(command_of(3'(k)));
      wait_drained();
      write_register(REG_HALF_PER, 32'd1);
      write_register(REG_SPI_MODE, 32'd0);
      write_register(REG_SS_POL, 32'd0);
      write_register(REG_ENABLE, 32'd1);

      push_command(command_of(KIND_SELECT));
      r = command_of(KIND_START);
      r.tx_data = 8'hFF;
      push_command(r);
      push_command(command_of(KIND_START));
      push_command(command_of(KIND_CLR_BRK));
      push_ticks(frame_ticks(), MISO_HIGH);
      r = command_of(KIND_START);
      r.tx_data = 8'h00;
      push_command(r);
      push_ticks(frame_ticks(), MISO_LOW);
      push_command(command_of(KIND_CLR_BRK));
      r = command_of(KIND_SET_BRK);
      {r.mosi_level, r.sck_level, r.miso} = 3'b011;
      push_command(r);
      r = command_of(KIND_SET_BRK);
      {r.mosi_level, r.sck_level, r.miso} = 3'b100;
      push_command(r);
      r = command_of(KIND_START);
      r.bit_count = 4'd0;
      push_command(r);
      push_ticks(frame_ticks(), MISO_RANDOM);
      r = command_of(KIND_START);
      r.bit_count = 4'd15;
      push_command(r);
      push_ticks(frame_ticks(), MISO_RANDOM);
      r = command_of(KIND_START);
      {r.bit_count, r.last_frame, r.end_hold, r.end_sck_level} = {4'd8, 3'b111};
      push_command(r);
      push_ticks(frame_ticks(), MISO_RANDOM);
      r = command_of(KIND_START);
      {r.bit_count, r.last_frame, r.end_hold, r.end_sck_level} = {4'd3, 3'b110};
      push_command(r);
      push_ticks(frame_ticks(), MISO_RANDOM);
      push_command(command_of(KIND_TICK));
      push_command(command_of(KIND_UNUSED));
      push_command(command_of(KIND_DESELECT));
      push_command(command_of(KIND_CLR_BRK));

      for (int ph = 0; ph < 8; ph++) begin
         finish_frames();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         mode = (ph < 4) ? ph : 7 - ph;
         if (ph % 2 == 1) write_register(REG_ENABLE, 32'd0);
         write_register(REG_SPI_MODE, mode);
         write_register(REG_SS_POL, (ph >> 1) & 1);
         write_register(REG_HALF_PER, (ph == 2) ? 0 : ph % 4 + 1);
         write_register(REG_ENABLE, 32'd1);
         queued_in_phase = 0;
         while (queued_in_phase < ITEMS_PER_PHASE) begin
            add_transaction();
            // in phase 3, hold the stream after each transaction past mid-phase until every result is back
            if (ph == 3 && queued_in_phase >= ITEMS_PER_PHASE / 2
                && queued_in_phase < ITEMS_PER_PHASE)
               wait_drained();
         end
      end

      // long timer setting: finish one half bit, then abort by disabling
      finish_frames();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_register(REG_HALF_PER, 32'd100);
      write_register(REG_SPI_MODE, 32'd3);
      push_command(command_of(KIND_START));
      push_ticks(110, MISO_RANDOM);
      wait_drained();
      write_register(REG_ENABLE, 32'd0);
      push_command(command_of(KIND_START));
      push_ticks(4, MISO_RANDOM);
      wait_drained();
      write_register(REG_ENABLE, 32'd1);
      write_register(REG_HALF_PER, 32'd1);
      add_transaction();
      finish_frames();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
